// ===== hdl/fsktsg_pkg.sv =====
package fsktsg_pkg;

   localparam int SAMPLE_BITS      = 12;
   localparam int MAX_SYMBOLS_DEF  = 1024;
   localparam int MAX_TONE_LEN_DEF = 256;

   localparam int CMD_W       = 2;
   localparam int ADDR_W      = 10;
   localparam int VALUE_W     = 12;
   localparam int POS_OUT_W   = 10;
   localparam int SYM_W       = 2;
   localparam int TDATA_W     = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WR_SYM   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WR_LOW   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_WR_HIGH  = 2'd3;

   localparam logic [SYM_W-1:0] SYM_LOW      = 2'd0;
   localparam logic [SYM_W-1:0] SYM_HIGH     = 2'd1;
   localparam logic [SYM_W-1:0] SYM_SILENCE  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_LOW_LEN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_LEN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_PERIODS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_PERIODS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MID_LEVEL   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STREAM_LEN  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TX_ENABLE   = 3'd6;

   typedef struct packed {
      logic [8:0]             low_tone_len;
      logic [8:0]             high_tone_len;
      logic [7:0]             low_periods;
      logic [7:0]             high_periods;
      logic [SAMPLE_BITS-1:0] mid_level;
      logic [10:0]            stream_length;
      logic                   tx_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      low_tone_len:  9'd96,
      high_tone_len: 9'd48,
      low_periods:   8'd3,
      high_periods:  8'd6,
      mid_level:     12'd2047,
      stream_length: 11'd1024,
      tx_enable:     1'b1
   };

   typedef struct packed {
      logic               tick;
      logic               sym_we;
      logic               low_we;
      logic               high_we;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
   } op_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [POS_OUT_W-1:0]   position;
      logic [SYM_W-1:0]       symbol;
      logic                   done;
   } result_type;

endpackage

// ===== hdl/fsktsg_ram.sv =====
module fsktsg_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fsktsg_csr.sv =====
module fsktsg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [fsktsg_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [fsktsg_pkg::CSR_DATA_W-1:0]   wr_data,
   output fsktsg_pkg::cfg_type                 cfg
);

   fsktsg_pkg::cfg_type cfg_ff;
   fsktsg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            fsktsg_pkg::REG_LOW_LEN:      cfg_in.low_tone_len  = wr_data[8:0];
            fsktsg_pkg::REG_HIGH_LEN:     cfg_in.high_tone_len = wr_data[8:0];
            fsktsg_pkg::REG_LOW_PERIODS:  cfg_in.low_periods   = wr_data[7:0];
            fsktsg_pkg::REG_HIGH_PERIODS: cfg_in.high_periods  = wr_data[7:0];
            fsktsg_pkg::REG_MID_LEVEL:
               cfg_in.mid_level = wr_data[fsktsg_pkg::SAMPLE_BITS-1:0];
            fsktsg_pkg::REG_STREAM_LEN:   cfg_in.stream_length = wr_data[10:0];
            fsktsg_pkg::REG_TX_ENABLE:    cfg_in.tx_enable     = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fsktsg_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/fsktsg_core.sv =====
module fsktsg_core #(
   parameter int MAX_SYMBOLS  = fsktsg_pkg::MAX_SYMBOLS_DEF,
   parameter int MAX_TONE_LEN = fsktsg_pkg::MAX_TONE_LEN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fsktsg_pkg::op_type     op,
   input  fsktsg_pkg::cfg_type    cfg,
   output fsktsg_pkg::result_type result
);

   localparam int PW = $clog2(MAX_SYMBOLS);
   localparam int TW = $clog2(MAX_TONE_LEN);
   localparam int SB = fsktsg_pkg::SAMPLE_BITS;

   logic [PW-1:0]  pos_ff, pos_in;
   logic [TW-1:0]  idx_ff, idx_in;
   logic [7:0]     pc_ff, pc_in;

   logic                         sym_fwd_ff, sym_fwd_in;
   logic [fsktsg_pkg::SYM_W-1:0] sym_fwd_data_ff;
   logic                         low_fwd_ff, low_fwd_in;
   logic [SB-1:0]                low_fwd_data_ff;
   logic                         high_fwd_ff, high_fwd_in;
   logic [SB-1:0]                high_fwd_data_ff;

   logic                         sym_wr, tab_ok, low_wr, high_wr;
   logic [PW-1:0]                sym_waddr, sym_raddr;
   logic [TW-1:0]                tab_waddr, tab_raddr;
   logic [fsktsg_pkg::SYM_W-1:0] sym_wdata, sym_q, cur_sym, play_sym;
   logic [SB-1:0]                tab_wdata, low_q, high_q, low_s, high_s, sample;
   logic                         is_low, is_high;
   logic [8:0]                   len_cfg;
   logic [7:0]                   per_cfg;
   logic [TW:0]                  idx_nx;
   logic [8:0]                   pc_nx;
   logic [PW:0]                  pos_nx;
   logic                         period_end, sym_end, wrap;

   // write decode
   assign sym_wr    = op.sym_we && (32'(op.addr) < MAX_SYMBOLS);
   assign tab_ok    = 32'(op.addr) < MAX_TONE_LEN;
   assign low_wr    = op.low_we && tab_ok;
   assign high_wr   = op.high_we && tab_ok;
   assign sym_waddr = PW'(op.addr);
   assign tab_waddr = TW'(op.addr);
   assign tab_wdata = SB'(op.value);
   assign sym_wdata = (op.value[fsktsg_pkg::VALUE_W-1:1] == '0) ?
                      {1'b0, op.value[0]} : fsktsg_pkg::SYM_SILENCE;

   // current symbol and table words, with write forwarding
   assign cur_sym = sym_fwd_ff ? sym_fwd_data_ff : sym_q;
   assign low_s   = low_fwd_ff ? low_fwd_data_ff : low_q;
   assign high_s  = high_fwd_ff ? high_fwd_data_ff : high_q;
   assign is_high = cur_sym == fsktsg_pkg::SYM_HIGH;
   assign is_low  = cur_sym == fsktsg_pkg::SYM_LOW;

   always_comb begin
      if (is_high) begin
         play_sym = fsktsg_pkg::SYM_HIGH;
         sample   = high_s;
         len_cfg  = cfg.high_tone_len;
         per_cfg  = cfg.high_periods;
      end else begin
         play_sym = is_low ? fsktsg_pkg::SYM_LOW : fsktsg_pkg::SYM_SILENCE;
         sample   = is_low ? low_s : cfg.mid_level;
         len_cfg  = cfg.low_tone_len;
         per_cfg  = cfg.low_periods;
      end
   end

   // a zero limit ends at once, an oversized one at the storage limit
   assign idx_nx     = {1'b0, idx_ff} + 1'b1;
   assign period_end = (32'(idx_nx) >= 32'(len_cfg)) || (32'(idx_nx) >= MAX_TONE_LEN);
   assign pc_nx      = {1'b0, pc_ff} + 9'd1;
   assign sym_end    = period_end && (pc_nx >= {1'b0, per_cfg});
   assign pos_nx     = {1'b0, pos_ff} + 1'b1;
   assign wrap       = (32'(pos_nx) >= 32'(cfg.stream_length)) ||
                       (32'(pos_nx) >= MAX_SYMBOLS);

   always_comb begin
      idx_in = idx_ff;
      pc_in  = pc_ff;
      pos_in = pos_ff;
      if (op.tick) begin
         if (!period_end) begin
            idx_in = idx_nx[TW-1:0];
         end else begin
            idx_in = '0;
            if (!sym_end) begin
               pc_in = pc_nx[7:0];
            end else begin
               pc_in  = '0;
               pos_in = wrap ? '0 : pos_nx[PW-1:0];
            end
         end
      end
   end

   // reads follow the next counter values so data lines up with the registered counters
   assign sym_raddr   = reset ? '0 : pos_in;
   assign tab_raddr   = reset ? '0 : idx_in;
   assign sym_fwd_in  = sym_wr && (sym_waddr == sym_raddr);
   assign low_fwd_in  = low_wr && (tab_waddr == tab_raddr);
   assign high_fwd_in = high_wr && (tab_waddr == tab_raddr);

   fsktsg_ram #(.WIDTH(fsktsg_pkg::SYM_W), .DEPTH(MAX_SYMBOLS)) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_wr),
      .wr_addr (sym_waddr),
      .wr_data (sym_wdata),
      .rd_addr (sym_raddr),
      .rd_data (sym_q)
   );

   fsktsg_ram #(.WIDTH(SB), .DEPTH(MAX_TONE_LEN)) u_low_ram (
      .clock   (clock),
      .wr_en   (low_wr),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (tab_raddr),
      .rd_data (low_q)
   );

   fsktsg_ram #(.WIDTH(SB), .DEPTH(MAX_TONE_LEN)) u_high_ram (
      .clock   (clock),
      .wr_en   (high_wr),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (tab_raddr),
      .rd_data (high_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         idx_ff      <= '0;
         pc_ff       <= '0;
         sym_fwd_ff  <= 1'b0;
         low_fwd_ff  <= 1'b0;
         high_fwd_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         pc_ff       <= pc_in;
         sym_fwd_ff  <= sym_fwd_in;
         low_fwd_ff  <= low_fwd_in;
         high_fwd_ff <= high_fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_fwd_data_ff  <= sym_wdata;
      low_fwd_data_ff  <= tab_wdata;
      high_fwd_data_ff <= tab_wdata;
   end

   assign result.sample   = sample;
   assign result.position = fsktsg_pkg::POS_OUT_W'(pos_ff);
   assign result.symbol   = play_sym;
   assign result.done     = sym_end;

   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      op.tick && period_end |=> idx_ff == '0)
      else $error("sample index not restarted at period end");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !(op.tick && sym_end) |=> $stable(pos_ff))
      else $error("stream position moved without a symbol end");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !op.tick |=> $stable(idx_ff) && $stable(pc_ff))
      else $error("counters moved without a tick");

   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      sym_fwd_ff |-> $past(op.sym_we))
      else $error("symbol forward without a symbol write");

endmodule

// ===== hdl/fsk_tone_sample_generator.sv =====
// FSK tone sample generator.
// req channel: one transaction per command. tuser holds the command (tick, write
// symbol, write low tone entry, write high tone entry); tdata holds address and
// value. Writes and ticks with transmission off produce no result.
// rsp channel: one transaction per enabled tick. tdata holds the sample and the
// stream position, tuser the playing symbol, tlast marks the last sample of a symbol.
// csr channel: register writes by index, always ready; write only while idle.
// Throughput: one command per cycle, back to back while no result waits on a
// low rsp_tready. The symbol store and both tone tables are read ahead from the
// next counter values, so the registered memory read never stalls the sample loop.
// Latency: a tick's result is registered and offered the cycle after acceptance.
// Stall: req_tready falls while a result waits and rsp_tready is low; the
// result holds until taken.
// Reset: counters, output valid and registers return to defaults at once; the
// symbol store and tables are undefined until written. req_tready is low in reset.
module fsk_tone_sample_generator #(
   parameter int MAX_SYMBOLS  = fsktsg_pkg::MAX_SYMBOLS_DEF,
   parameter int MAX_TONE_LEN = fsktsg_pkg::MAX_TONE_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] address, [21:10] value, [23:22] zero
   input  logic [fsktsg_pkg::TDATA_W-1:0]      req_tdata,
   // [1:0] command
   input  logic [fsktsg_pkg::CMD_W-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] sample, [21:12] symbol_position, [23:22] zero
   output logic [fsktsg_pkg::TDATA_W-1:0]      rsp_tdata,
   // [1:0] playing_symbol
   output logic [fsktsg_pkg::SYM_W-1:0]        rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fsktsg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsktsg_pkg::CSR_DATA_W-1:0]   csr_data
);

   fsktsg_pkg::cfg_type    cfg;
   fsktsg_pkg::op_type     op;
   fsktsg_pkg::result_type result;
   fsktsg_pkg::result_type rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   req_acc;

   assign csr_ready  = 1'b1;
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   assign op.tick    = req_acc && (req_tuser == fsktsg_pkg::CMD_TICK) && cfg.tx_enable;
   assign op.sym_we  = req_acc && (req_tuser == fsktsg_pkg::CMD_WR_SYM);
   assign op.low_we  = req_acc && (req_tuser == fsktsg_pkg::CMD_WR_LOW);
   assign op.high_we = req_acc && (req_tuser == fsktsg_pkg::CMD_WR_HIGH);
   assign op.addr    = req_tdata[fsktsg_pkg::ADDR_W-1:0];
   assign op.value   =
      req_tdata[fsktsg_pkg::ADDR_W+fsktsg_pkg::VALUE_W-1:fsktsg_pkg::ADDR_W];

   fsktsg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   fsktsg_core #(.MAX_SYMBOLS(MAX_SYMBOLS), .MAX_TONE_LEN(MAX_TONE_LEN)) u_core (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op.tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.tick) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.position, rsp_ff.sample};
   assign rsp_tuser  = rsp_ff.symbol;
   assign rsp_tlast  = rsp_ff.done;

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      op.tick |=> rsp_valid_ff)
      else $error("enabled tick produced no result");

endmodule
